[rtl/core/tlif_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlif_pkg
// Shared types, constants and the converter-code table for the thermistor
// lookup-and-interpolate core.
// ----------------------------------------------------------------------------
package tlif_pkg;

    localparam int ADC_W         = 10;
    localparam int TEMP_W        = 11;
    localparam int QUOT_W        = 8;
    localparam int NUM_W         = ADC_W + QUOT_W;
    localparam int SCALED_W      = 18;
    localparam int MAG_W         = 16;
    localparam int RECIP_W       = 13;
    localparam int PROD_W        = MAG_W + RECIP_W;
    localparam int RECIP_SHIFT   = 19;
    localparam int WHOLE_W       = PROD_W - RECIP_SHIFT;

    localparam int TEMP_OFFSET_C = 20;
    localparam int F_SCALE       = 180;
    localparam int F_OFFSET      = 32;
    localparam int RECIP_100     = 5243;

    localparam logic signed [TEMP_W-1:0] TEMP_UNDER = -11'sd999;
    localparam logic signed [TEMP_W-1:0] TEMP_OVER  = 11'sd999;

    localparam int DEFAULT_ENTRIES = 90;
    localparam logic [ADC_W-1:0] ADC_ROM [DEFAULT_ENTRIES] = '{
        10'd105, 10'd110, 10'd116, 10'd121, 10'd127, 10'd133, 10'd139, 10'd145,
        10'd152, 10'd159, 10'd165, 10'd173, 10'd180, 10'd187, 10'd195, 10'd203,
        10'd211, 10'd219, 10'd227, 10'd236, 10'd245, 10'd254, 10'd264, 10'd273,
        10'd283, 10'd293, 10'd303, 10'd313, 10'd324, 10'd334, 10'd345, 10'd355,
        10'd366, 10'd377, 10'd388, 10'd399, 10'd410, 10'd422, 10'd433, 10'd444,
        10'd455, 10'd467, 10'd478, 10'd489, 10'd500, 10'd512, 10'd523, 10'd534,
        10'd545, 10'd555, 10'd566, 10'd577, 10'd588, 10'd598, 10'd608, 10'd619,
        10'd629, 10'd639, 10'd648, 10'd658, 10'd667, 10'd677, 10'd686, 10'd695,
        10'd704, 10'd712, 10'd721, 10'd729, 10'd737, 10'd745, 10'd753, 10'd760,
        10'd768, 10'd775, 10'd782, 10'd789, 10'd795, 10'd802, 10'd808, 10'd814,
        10'd820, 10'd826, 10'd832, 10'd837, 10'd843, 10'd848, 10'd853, 10'd858,
        10'd863, 10'd867
    };

    typedef enum logic [1:0] {
        RANGE_IN    = 2'd0,
        RANGE_UNDER = 2'd1,
        RANGE_OVER  = 2'd2
    } t_range;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_SRCH,
        ST_CMP,
        ST_MUL,
        ST_DIV,
        ST_SCALE,
        ST_RECIP,
        ST_CONV,
        ST_DONE
    } t_state;

    // Entries past the stock table saturate at full scale.
    function automatic logic [ADC_W-1:0] rom_value(input int unsigned idx);
        logic [ADC_W-1:0] val;
        if (idx < DEFAULT_ENTRIES) begin
            val = ADC_ROM[idx];
        end else begin
            val = '1;
        end
        return val;
    endfunction

endpackage
`default_nettype wire

[rtl/core/tlif_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlif_rom
// Synchronous table of rising converter codes, one per degree C, with a
// registered read port.
// ----------------------------------------------------------------------------
module tlif_rom
    import tlif_pkg::*;
#(
    parameter int TABLE_ENTRIES = 90,
    parameter int ADDR_W        = 7
) (
    input  wire logic              i_clk,
    input  wire logic [ADDR_W-1:0] i_addr,
    output logic      [ADC_W-1:0]  o_data
);

    logic [ADC_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (32'(i_addr) < 32'(TABLE_ENTRIES)) begin
            r_data <= rom_value(32'(i_addr));
        end else begin
            r_data <= '1;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

[rtl/core/tlif_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlif_div
// Restoring divider, one quotient bit per cycle, for the interpolation step.
// The quotient is known to fit in QUOT_W bits.
// ----------------------------------------------------------------------------
module tlif_div
    import tlif_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [ADC_W-1:0]  i_den,
    output logic                   o_done,
    output logic      [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(QUOT_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADC_W-1:0]  r_rem;
    logic [ADC_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_num_lo;
    logic [QUOT_W-1:0] r_quot;

    logic [ADC_W:0]    n_trial;
    logic              n_fit;
    logic [ADC_W-1:0]  n_rem;

    always_comb begin
        n_trial = {r_rem, r_num_lo[QUOT_W-1]};
        n_fit   = n_trial >= {1'b0, r_den};
        if (n_fit) begin
            n_rem = ADC_W'(n_trial - {1'b0, r_den});
        end else begin
            n_rem = n_trial[ADC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem    <= i_num[NUM_W-1:QUOT_W];
            r_num_lo <= i_num[QUOT_W-1:0];
            r_den    <= i_den;
            r_quot   <= '0;
        end else if (r_busy) begin
            r_rem    <= n_rem;
            r_num_lo <= {r_num_lo[QUOT_W-2:0], 1'b0};
            r_quot   <= {r_quot[QUOT_W-2:0], n_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
`default_nettype wire

[rtl/core/thermistor_lut_interp_to_fahrenheit_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_lut_interp_to_fahrenheit_core
// Converts a 10-bit thermistor divider reading to whole degrees Fahrenheit.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A reading is checked against the first and
// last table entries, then a binary search over the table ROM brackets it,
// each probe reading through the ROM's registered read port, then a
// bit-serial divide interpolates and a reciprocal multiply scales to degrees.
// The search makes at most ceil(log2(TABLE_ENTRIES)) probes. A reading below
// the table goes straight to the result after the first-entry check, and one
// above it after the last-entry check. The input accepts again in the cycle
// after the result is loaded, and a stalled result holds the input stalled.
// Readings below the table give -999 (status 1), above it 999 (status 2).
// A finished result sits in the output register while the next item is
// accepted.
// ----------------------------------------------------------------------------
module thermistor_lut_interp_to_fahrenheit_core
    import tlif_pkg::*;
#(
    parameter int TABLE_ENTRIES = 90
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic        [ADC_W-1:0]  i_adc_sample,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed      [TEMP_W-1:0] o_temperature_f,
    output logic             [1:0]        o_range_status
);

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);

    t_state                    r_state;
    t_state                    n_state;
    logic                      r_out_valid;
    logic signed [TEMP_W-1:0]  r_temp_f;
    t_range                    r_status;

    logic [ADC_W-1:0]          r_sample;
    logic [ADDR_W-1:0]         r_lo;
    logic [IDX_W-1:0]          r_hi;
    logic [ADDR_W-1:0]         r_mid;
    logic [ADC_W-1:0]          r_lo_val;
    logic [ADC_W-1:0]          r_hi_val;
    logic                      r_neg;
    logic [MAG_W-1:0]          r_mag;
    logic [PROD_W-1:0]         r_prod;
    logic signed [TEMP_W-1:0]  r_res_temp;
    t_range                    r_res_status;

    logic [ADDR_W-1:0]         n_addr;
    logic                      n_accept;
    logic                      n_load_out;
    logic                      n_div_start;
    logic [NUM_W-1:0]          n_num;
    logic [ADC_W-1:0]          n_den;
    logic [IDX_W:0]            n_mid_sum;
    logic                      n_more;
    logic signed [SCALED_W-1:0] n_scaled;
    logic [WHOLE_W-1:0]        n_whole;

    logic [ADC_W-1:0]          w_rom_data;
    logic                      w_div_done;
    logic [QUOT_W-1:0]         w_quot;

    tlif_rom #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ADDR_W        (ADDR_W)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (n_addr),
        .o_data (w_rom_data)
    );

    tlif_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_comb begin
        n_mid_sum = (IDX_W + 1)'(r_lo) + (IDX_W + 1)'(r_hi);
        n_more    = (r_hi - IDX_W'(r_lo)) > IDX_W'(1);
        if (r_hi == IDX_W'(TABLE_ENTRIES)) begin
            n_num = '0;
            n_den = ADC_W'(1);
        end else begin
            n_num = NUM_W'(r_sample - r_lo_val) * NUM_W'(F_SCALE);
            n_den = r_hi_val - r_lo_val;
        end
        n_scaled = ($signed(SCALED_W'(r_lo)) - SCALED_W'(TEMP_OFFSET_C))
                   * SCALED_W'(F_SCALE) + $signed(SCALED_W'(w_quot));
        n_whole  = r_prod[PROD_W-1:RECIP_SHIFT];
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = '0;
        n_accept    = 1'b0;
        n_load_out  = 1'b0;
        n_div_start = 1'b0;
        o_in_stall  = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_accept = 1'b1;
                    n_state  = ST_CHK_LO;
                end
            end
            ST_CHK_LO: begin
                n_addr = ADDR_W'(TABLE_ENTRIES - 1);
                if (r_sample < w_rom_data) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CHK_HI;
                end
            end
            ST_CHK_HI: begin
                if (r_sample > w_rom_data) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                n_addr = n_mid_sum[ADDR_W:1];
                if (n_more) begin
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_CMP: begin
                n_state = ST_SRCH;
            end
            ST_MUL: begin
                n_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: begin
                n_state = ST_RECIP;
            end
            ST_RECIP: begin
                n_state = ST_CONV;
            end
            ST_CONV: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (n_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_sample <= i_adc_sample;
        end
        if (n_load_out) begin
            r_temp_f <= r_res_temp;
            r_status <= r_res_status;
        end
        case (r_state)
            ST_CHK_LO: begin
                r_lo_val     <= w_rom_data;
                r_res_temp   <= TEMP_UNDER;
                r_res_status <= RANGE_UNDER;
            end
            ST_CHK_HI: begin
                r_lo         <= '0;
                r_hi         <= IDX_W'(TABLE_ENTRIES);
                r_res_temp   <= TEMP_OVER;
                r_res_status <= RANGE_OVER;
            end
            ST_SRCH: begin
                r_mid <= n_mid_sum[ADDR_W:1];
            end
            ST_CMP: begin
                if (w_rom_data <= r_sample) begin
                    r_lo     <= r_mid;
                    r_lo_val <= w_rom_data;
                end else begin
                    r_hi     <= IDX_W'(r_mid);
                    r_hi_val <= w_rom_data;
                end
            end
            ST_SCALE: begin
                r_neg <= n_scaled < 0;
                if (n_scaled < 0) begin
                    r_mag <= MAG_W'(-n_scaled);
                end else begin
                    r_mag <= MAG_W'(n_scaled);
                end
            end
            ST_RECIP: begin
                r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP_100);
            end
            ST_CONV: begin
                r_res_status <= RANGE_IN;
                if (r_neg) begin
                    r_res_temp <= TEMP_W'(F_OFFSET) - TEMP_W'(n_whole);
                end else begin
                    r_res_temp <= TEMP_W'(n_whole) + TEMP_W'(F_OFFSET);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_temperature_f = r_temp_f;
    assign o_range_status  = r_status;

endmodule
`default_nettype wire

[dv/tb_thermistor_lut_interp_to_fahrenheit_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_thermistor_lut_interp_to_fahrenheit_core
// Self-checking bench for the thermistor lookup-and-interpolate core: a
// directed table of readings at the range edges and on table entries, then
// random readings biased into the table. Results are checked against typed
// rows or a local interpolation predictor; both ports idle and stall at random.
// ----------------------------------------------------------------------------
module tb_thermistor_lut_interp_to_fahrenheit_core
    import tlif_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENTRIES    = 90;
    localparam int ZERO_C_IDX   = 20;
    localparam int SCALE_F      = 180;
    localparam int CENTI        = 100;
    localparam int FREEZE_F     = 32;
    localparam int UNDER_F      = -999;
    localparam int OVER_F       = 999;
    localparam int N_RANDOM     = 1750;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_PRINTS   = 40;

    localparam logic [ADC_W-1:0] CAL_TABLE [N_ENTRIES] = '{
        10'd105, 10'd110, 10'd116, 10'd121, 10'd127, 10'd133, 10'd139, 10'd145,
        10'd152, 10'd159, 10'd165, 10'd173, 10'd180, 10'd187, 10'd195, 10'd203,
        10'd211, 10'd219, 10'd227, 10'd236, 10'd245, 10'd254, 10'd264, 10'd273,
        10'd283, 10'd293, 10'd303, 10'd313, 10'd324, 10'd334, 10'd345, 10'd355,
        10'd366, 10'd377, 10'd388, 10'd399, 10'd410, 10'd422, 10'd433, 10'd444,
        10'd455, 10'd467, 10'd478, 10'd489, 10'd500, 10'd512, 10'd523, 10'd534,
        10'd545, 10'd555, 10'd566, 10'd577, 10'd588, 10'd598, 10'd608, 10'd619,
        10'd629, 10'd639, 10'd648, 10'd658, 10'd667, 10'd677, 10'd686, 10'd695,
        10'd704, 10'd712, 10'd721, 10'd729, 10'd737, 10'd745, 10'd753, 10'd760,
        10'd768, 10'd775, 10'd782, 10'd789, 10'd795, 10'd802, 10'd808, 10'd814,
        10'd820, 10'd826, 10'd832, 10'd837, 10'd843, 10'd848, 10'd853, 10'd858,
        10'd863, 10'd867
    };

    typedef struct packed {
        logic [ADC_W-1:0]         sample;
        logic signed [TEMP_W-1:0] temp;
        t_range                   status;
    } t_reading;

    typedef struct packed {
        logic [ADC_W-1:0]         sample;
        logic                     typed;
        logic signed [TEMP_W-1:0] temp;
        t_range                   status;
    } t_dir_row;

    localparam int N_DIRECTED = 19;
    t_dir_row dir_rows [N_DIRECTED] = '{
        '{10'd0,    1'b1, -11'sd999, RANGE_UNDER},
        '{10'd104,  1'b1, -11'sd999, RANGE_UNDER},
        '{10'd105,  1'b1, -11'sd4,   RANGE_IN},
        '{10'd106,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd240,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd244,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd245,  1'b1, 11'sd32,   RANGE_IN},
        '{10'd246,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd545,  1'b1, 11'sd82,   RANGE_IN},
        '{10'd546,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd341,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd682,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd511,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd512,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd866,  1'b0, 11'sd0,    RANGE_IN},
        '{10'd867,  1'b1, 11'sd156,  RANGE_IN},
        '{10'd868,  1'b1, 11'sd999,  RANGE_OVER},
        '{10'd1023, 1'b1, 11'sd999,  RANGE_OVER},
        '{10'd700,  1'b0, 11'sd0,    RANGE_IN}
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [ADC_W-1:0]         i_adc_sample;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic signed [TEMP_W-1:0] o_temperature_f;
    logic [1:0]               o_range_status;

    t_reading pending_readings [$];
    int       err_count;
    int       stall_left;
    bit       calm;

    thermistor_lut_interp_to_fahrenheit_core #(
        .TABLE_ENTRIES(N_ENTRIES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_adc_sample   (i_adc_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_temperature_f(o_temperature_f),
        .o_range_status (o_range_status)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_reading convert_reading(input logic [ADC_W-1:0] sample);
        t_reading r;
        int       idx;
        int       lo;
        int       hi;
        int       scaled;
        bit       hit;
        r.sample = sample;
        r.status = RANGE_IN;
        hit      = 1'b0;
        scaled   = (N_ENTRIES - 1 - ZERO_C_IDX) * SCALE_F;
        if (sample < CAL_TABLE[0]) begin
            r.temp   = TEMP_W'(UNDER_F);
            r.status = RANGE_UNDER;
        end else if (sample > CAL_TABLE[N_ENTRIES-1]) begin
            r.temp   = TEMP_W'(OVER_F);
            r.status = RANGE_OVER;
        end else begin
            for (idx = 1; idx < N_ENTRIES; idx++) begin
                if (!hit && CAL_TABLE[idx] > sample) begin
                    lo     = int'(CAL_TABLE[idx-1]);
                    hi     = int'(CAL_TABLE[idx]);
                    scaled = (idx - 1 - ZERO_C_IDX) * SCALE_F;
                    if (hi > lo) begin
                        scaled = scaled + ((int'(sample) - lo) * SCALE_F) / (hi - lo);
                    end
                    hit = 1'b1;
                end
            end
            // signed int division truncates toward zero
            r.temp = TEMP_W'(scaled / CENTI + FREEZE_F);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic logic [ADC_W-1:0] pick_sample();
        int r;
        int e;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return ADC_W'($urandom_range(105, 867));
        end else if (r < 82) begin
            e = int'(CAL_TABLE[$urandom_range(0, N_ENTRIES - 1)]) + $urandom_range(0, 2) - 1;
            return ADC_W'(e);
        end else begin
            return ADC_W'($urandom_range(0, 1023));
        end
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    task automatic send_reading(input logic [ADC_W-1:0] sample, input t_reading want);
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 1) == 0) ? 0 : pick_gap());
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_adc_sample <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_readings.push_back(want);
    endtask

    task automatic wait_drained();
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    // result stall
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_out_stall <= 1'b1;
            stall_left = pick_gap() - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_readings.size() == 0) begin
                report_mismatch($sformatf("unexpected item temp=%0d status=%0d",
                                          o_temperature_f, o_range_status));
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_f !== want.temp) begin
                    report_mismatch($sformatf("adc=%0d temp got %0d want %0d",
                                              want.sample, o_temperature_f, want.temp));
                end
                if (o_range_status !== want.status) begin
                    report_mismatch($sformatf("adc=%0d status got %0d want %0d",
                                              want.sample, o_range_status, want.status));
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_reading want;
        logic [ADC_W-1:0] sample;
        int n;
        err_count    = 0;
        stall_left   = 0;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_adc_sample = '0;
        i_out_stall  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < N_DIRECTED; n++) begin
            if (dir_rows[n].typed) begin
                want.sample = dir_rows[n].sample;
                want.temp   = dir_rows[n].temp;
                want.status = dir_rows[n].status;
            end else begin
                want = convert_reading(dir_rows[n].sample);
            end
            send_reading(dir_rows[n].sample, want);
        end

        // hold until the directed items have all returned
        i_in_valid <= 1'b0;
        wait_drained();

        for (n = 0; n < N_RANDOM; n++) begin
            if (n == 600) begin
                calm = 1'b1;
            end else if (n == 800) begin
                calm = 1'b0;
            end
            if (n == 1100) begin
                i_in_valid <= 1'b0;
                wait_drained();
            end
            sample = pick_sample();
            send_reading(sample, convert_reading(sample));
        end
        i_in_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
rtl/core/tlif_pkg.sv
rtl/core/tlif_rom.sv
rtl/core/tlif_div.sv
rtl/core/thermistor_lut_interp_to_fahrenheit_core.sv
dv/tb_thermistor_lut_interp_to_fahrenheit_core.sv
